### hdl/shuffle_playlist_sequencer_top_macros.svh
// assertion helpers for the sequencer top level
`ifndef SHUFFLE_PLAYLIST_SEQUENCER_TOP_MACROS_SVH
`define SHUFFLE_PLAYLIST_SEQUENCER_TOP_MACROS_SVH

`define SPS_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("sequencer assertion failed");

`define SPS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("sequencer assertion failed");

`endif

### hdl/shplseq_pkg.sv
package shplseq_pkg;

    localparam int DEFAULT_MAX_ITEMS = 1024;

    localparam int CUR_W    = 10;
    localparam int CFG_CNT_W = 11;
    localparam int MODE_W   = 2;
    localparam int SEED_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

    localparam logic [MODE_W-1:0] MODE_SEQ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REV = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 2'd2;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
    } mod_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_status_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

endpackage

### hdl/shplseq_ram.sv
module shplseq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/shplseq_mod_unit.sv
module shplseq_mod_unit #(
    parameter int CW = 11
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  shplseq_pkg::mod_req_t     req,
    input  logic [CW-1:0]             divisor,
    output logic [CW-1:0]             rem,
    output shplseq_pkg::mod_status_t  status
);

    import shplseq_pkg::*;

    logic [31:0]          dvd_reg, dvd_next;
    logic [CW-1:0]        dvs_reg, dvs_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW:0]          shifted;
    logic [CW:0]          diff;

    always_comb begin
        shifted   = {rem_reg, dvd_reg[31]};
        diff      = shifted - {1'b0, dvs_reg};
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            dvd_next  = req.dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[30:0], 1'b0};
            rem_next = (shifted >= {1'b0, dvs_reg}) ? diff[CW-1:0] : shifted[CW-1:0];
            cnt_next = DIV_CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign rem         = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

### hdl/shuffle_playlist_sequencer_top.sv
// playlist index sequencer
// requests come in on the s_ stream: s_tuser[0] selects step forward (0) or
// step backward (1), s_tdata[9:0] holds the index now shown. each request gives
// one result on the m_ stream: m_tdata[9:0] is the next index and m_tuser[0]
// flags an empty list. registers (item count, play mode, random seed) are
// written through the cfg_ port; the user must write them only while the
// block is idle, and the block itself does not enforce this.
// a sequential, reverse or backward step runs the shared 32-step remainder
// unit and then pushes the result; a shuffled step from a live round reads
// the order table through its registered read port and pushes that entry.
// when a round is used up or the count or mode was written, the request first
// reshuffles: the table is filled with 0..n-1, then each entry above 0 takes
// a remainder run and a read-read-write-write swap on the dual-port table.
// s_tready is high only while no request is in work; a finished result waits
// in the output register while the next request is taken, and a stalled
// receiver holds the block once a second result is ready.
// reset clears the control state, loads the generator with seed 1 and marks
// a shuffle as due; the order table is not cleared and is written by the
// first shuffle before it is read.
module shuffle_playlist_sequencer_top #(
    parameter int MAX_ITEMS = shplseq_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // current_index
    input  logic [0:0]                        s_tuser,  // func
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,  // next_index
    output logic [0:0]                        m_tuser,  // list_empty
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [shplseq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [shplseq_pkg::CFG_DATA_W-1:0] cfg_data
);

    import shplseq_pkg::*;

    localparam int IW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_STEP_DIV = 16'h0002,
        S_FILL     = 16'h0004,
        S_RAND     = 16'h0008,
        S_SHUF_DIV = 16'h0010,
        S_RDI      = 16'h0020,
        S_RDJ      = 16'h0040,
        S_WRI      = 16'h0080,
        S_WRJ      = 16'h0100,
        S_F0       = 16'h0200,
        S_F1       = 16'h0400,
        S_F2       = 16'h0800,
        S_F3       = 16'h1000,
        S_GET      = 16'h2000,
        S_TAKE     = 16'h4000,
        S_PUSH     = 16'h8000
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_CNT_W-1:0]  count_reg, count_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [SEED_W-1:0]     rng_reg, rng_next;
    logic                  pending_reg, pending_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic                  fix_reg, fix_next;
    logic [CUR_W-1:0]      cur_reg, cur_next;
    logic [IW-1:0]         k_reg, k_next;
    logic [IW-1:0]         i_reg, i_next;
    logic [IW-1:0]         j_reg, j_next;
    logic [IW-1:0]         ti_reg, ti_next;
    logic [IW-1:0]         t0_reg, t0_next;
    logic [CUR_W-1:0]      res_idx_reg, res_idx_next;
    logic                  res_empty_reg, res_empty_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CUR_W-1:0]      out_idx_reg, out_idx_next;
    logic                  out_empty_reg, out_empty_next;

    logic [CW-1:0]         n;
    logic                  s_accept;
    logic                  out_free;
    logic                  swap_hit;
    logic [31:0]           rem32;
    logic [31:0]           rd32;

    mod_req_t              mod_req;
    mod_status_t           mod_status;
    logic [CW-1:0]         mod_divisor;
    logic [CW-1:0]         mod_rem;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [IW-1:0]         ram_wdata;
    logic [IW-1:0]         ram_raddr;
    logic [IW-1:0]         ram_rdata;

    shplseq_mod_unit #(
        .CW(CW)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .divisor (mod_divisor),
        .rem     (mod_rem),
        .status  (mod_status)
    );

    shplseq_ram #(
        .WIDTH(IW),
        .DEPTH(MAX_ITEMS)
    ) u_order_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (32'(count_reg) > 32'(MAX_ITEMS)) begin
            n = CW'(MAX_ITEMS);
        end else begin
            n = CW'(count_reg);
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign swap_hit  = (32'(t0_reg) == 32'(cur_reg));
    assign rem32     = 32'(mod_rem);
    assign rd32      = 32'(ram_rdata);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        rng_next       = rng_reg;
        pending_next   = pending_reg;
        pos_next       = pos_reg;
        fix_next       = fix_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ti_next        = ti_reg;
        t0_next        = t0_reg;
        res_idx_next   = res_idx_reg;
        res_empty_next = res_empty_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_idx_next   = out_idx_reg;
        out_empty_next = out_empty_reg;
        mod_req.start    = 1'b0;
        mod_req.dividend = '0;
        mod_divisor      = n;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    cur_next       = s_tdata[CUR_W-1:0];
                    res_empty_next = 1'b0;
                    if (n == '0) begin
                        res_idx_next   = '0;
                        res_empty_next = 1'b1;
                        state_next     = S_PUSH;
                    end else if (s_tuser[0] || mode_reg == MODE_REV) begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = 32'(s_tdata[CUR_W-1:0]) + 32'(n) - 32'd1;
                        state_next       = S_STEP_DIV;
                    end else if (mode_reg == MODE_RND) begin
                        k_next = '0;
                        if (pending_reg) begin
                            pending_next = 1'b0;
                            fix_next     = 1'b0;
                            pos_next     = '0;
                            state_next   = S_FILL;
                        end else if (pos_reg >= n) begin
                            fix_next   = 1'b1;
                            pos_next   = '0;
                            state_next = S_FILL;
                        end else begin
                            state_next = S_GET;
                        end
                    end else begin
                        mod_req.start    = 1'b1;
                        mod_req.dividend = 32'(s_tdata[CUR_W-1:0]) + 32'd1;
                        state_next       = S_STEP_DIV;
                    end
                end
            end
            S_STEP_DIV: begin
                if (mod_status.done) begin
                    res_idx_next = rem32[CUR_W-1:0];
                    state_next   = S_PUSH;
                end
            end
            S_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = k_reg;
                ram_wdata = k_reg;
                k_next    = IW'(k_reg + 1'b1);
                if (CW'(k_reg) == CW'(n - 1'b1)) begin
                    i_next = IW'(n - 1'b1);
                    if (n == CW'(1)) begin
                        state_next = S_GET;
                    end else begin
                        state_next = S_RAND;
                    end
                end
            end
            S_RAND: begin
                rng_next         = xorshift32(rng_reg);
                mod_req.start    = 1'b1;
                mod_req.dividend = xorshift32(rng_reg);
                mod_divisor      = CW'(CW'(i_reg) + 1'b1);
                state_next       = S_SHUF_DIV;
            end
            S_SHUF_DIV: begin
                if (mod_status.done) begin
                    j_next     = IW'(mod_rem);
                    state_next = S_RDI;
                end
            end
            S_RDI: begin
                ram_raddr  = i_reg;
                state_next = S_RDJ;
            end
            S_RDJ: begin
                ram_raddr  = j_reg;
                ti_next    = ram_rdata;
                state_next = S_WRI;
            end
            S_WRI: begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg;
                ram_wdata  = ram_rdata;
                state_next = S_WRJ;
            end
            S_WRJ: begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = ti_reg;
                i_next    = IW'(i_reg - 1'b1);
                if (i_reg == IW'(1)) begin
                    state_next = fix_reg ? S_F0 : S_GET;
                end else begin
                    state_next = S_RAND;
                end
            end
            S_F0: begin
                ram_raddr  = '0;
                state_next = S_F1;
            end
            S_F1: begin
                ram_raddr  = IW'(1);
                t0_next    = ram_rdata;
                state_next = S_F2;
            end
            S_F2: begin
                if (swap_hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = ram_rdata;
                end
                state_next = S_F3;
            end
            S_F3: begin
                if (swap_hit) begin
                    ram_we    = 1'b1;
                    ram_waddr = IW'(1);
                    ram_wdata = t0_reg;
                end
                state_next = S_GET;
            end
            S_GET: begin
                ram_raddr  = pos_reg[IW-1:0];
                state_next = S_TAKE;
            end
            S_TAKE: begin
                res_idx_next = rd32[CUR_W-1:0];
                pos_next     = CW'(pos_reg + 1'b1);
                state_next   = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_empty_next = res_empty_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ITEM_COUNT: begin
                    count_next   = cfg_data[CFG_CNT_W-1:0];
                    pending_next = 1'b1;
                end
                REG_PLAY_MODE: begin
                    mode_next    = cfg_data[MODE_W-1:0];
                    pending_next = 1'b1;
                end
                REG_RANDOM_SEED: begin
                    rng_next = cfg_data[SEED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            mode_reg      <= MODE_SEQ;
            rng_reg       <= SEED_RESET;
            pending_reg   <= 1'b1;
            pos_reg       <= '0;
            fix_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            rng_reg       <= rng_next;
            pending_reg   <= pending_next;
            pos_reg       <= pos_next;
            fix_reg       <= fix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        k_reg         <= k_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        ti_reg        <= ti_next;
        t0_reg        <= t0_next;
        res_idx_reg   <= res_idx_next;
        res_empty_reg <= res_empty_next;
        out_idx_reg   <= out_idx_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 16'(out_idx_reg);
    assign m_tuser  = out_empty_reg;

`include "shuffle_playlist_sequencer_top_macros.svh"

    // an empty-list result always carries index zero
    `SPS_ASSERT_NOW(a_empty_zero, m_tvalid && m_tuser[0], m_tdata == 16'd0)
    // the remainder unit runs only while the sequencer waits on it
    `SPS_ASSERT_NOW(a_mod_owner, mod_status.busy,
                    state_reg == S_STEP_DIV || state_reg == S_SHUF_DIV)
    // a live round never runs past the list
    `SPS_ASSERT_NOW(a_round_bound, !pending_reg && state_reg == S_IDLE, pos_reg <= n)
    // no new request is taken in the cycle after one was accepted
    `SPS_ASSERT_NEXT(a_one_at_a_time, s_accept, !s_tready)

endmodule

### verif/tb_shuffle_playlist_sequencer_top.sv
`timescale 1ns / 100ps

module tb_shuffle_playlist_sequencer_top;
    import shplseq_pkg::*;

    localparam int unsigned DECK_DEPTH   = DEFAULT_MAX_ITEMS;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned LONG_HOLD    = 600;
    localparam int unsigned CYCLE_LIMIT  = 8_000_000;
    localparam int unsigned ITEM_TARGET  = 1700;
    localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [CUR_W-1:0] next_index;
        logic             list_empty;
    } playlist_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    shuffle_playlist_sequencer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 0;
    end

    // playlist state mirror
    logic [CFG_CNT_W-1:0] cfg_count = '0;
    logic [MODE_W-1:0]    cfg_mode = MODE_SEQ;
    logic [CUR_W-1:0]     deck [0:DECK_DEPTH-1];
    logic [CFG_CNT_W-1:0] deck_pos = '0;
    logic                 deal_pending = 1'b1;
    logic [SEED_W-1:0]    rng_state = SEED_RESET;

    playlist_result_t awaited_steps [$];
    playlist_result_t head_step;

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned reg_writes = 0;
    int unsigned shuffles_dealt = 0;
    int unsigned swaps_taken = 0;
    int unsigned burst_left = 0;
    logic        valid_on = 1'b0;
    logic        steady_flow = 1'b0;
    logic        steady_sink = 1'b0;
    int unsigned hold_calls = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    logic [15:0] sink_pat = 16'hB5A7;
    logic [5:0]  sink_age = '0;

    function automatic logic [SEED_W-1:0] rng_advance();
        logic [SEED_W-1:0] x;
        x = rng_state;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        rng_state = x;
        return x;
    endfunction

    function automatic void deal_deck(input int unsigned n);
        int unsigned i;
        int unsigned j;
        logic [CUR_W-1:0] t;
        deck_pos = '0;
        for (i = 0; i < n; i++) deck[i] = i[CUR_W-1:0];
        for (i = n - 1; i > 0; i--) begin
            j = rng_advance() % (i + 1);
            t = deck[i];
            deck[i] = deck[j];
            deck[j] = t;
        end
        shuffles_dealt++;
    endfunction

    function automatic playlist_result_t next_in_playlist(input logic back,
                                                          input logic [CUR_W-1:0] cur);
        int unsigned n;
        logic [CUR_W-1:0] t;
        playlist_result_t r;
        n = (cfg_count > DECK_DEPTH) ? DECK_DEPTH : int'(cfg_count);
        r = '0;
        if (n == 0) begin
            r.list_empty = 1'b1;
        end else if (back || cfg_mode == MODE_REV) begin
            r.next_index = CUR_W'((cur + n - 1) % n);
        end else if (cfg_mode == MODE_RND) begin
            if (deal_pending) begin
                deal_deck(n);
                deal_pending = 1'b0;
            end else if (deck_pos >= n) begin
                deal_deck(n);
                if (n > 1 && deck[0] == cur) begin
                    t = deck[0];
                    deck[0] = deck[1];
                    deck[1] = t;
                    swaps_taken++;
                end
            end
            r.next_index = deck[deck_pos];
            deck_pos = deck_pos + 1'b1;
        end else begin
            r.next_index = CUR_W'((cur + 1) % n);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycle_count, what, got, want);
    endtask

    task automatic pause_sender();
        if (valid_on) begin
            s_tvalid <= 1'b0;
            valid_on = 1'b0;
        end
    endtask

    task automatic send_step(input logic back, input logic [CUR_W-1:0] cur,
                             output logic [CUR_W-1:0] predicted);
        playlist_result_t r;
        int unsigned gap;
        if (!valid_on) begin
            s_tvalid <= 1'b1;
            valid_on = 1'b1;
        end
        s_tdata <= {{(16-CUR_W){1'b0}}, cur};
        s_tuser <= back;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = next_in_playlist(back, cur);
        awaited_steps.push_back(r);
        predicted = r.next_index;
        items_sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = steady_flow ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                pause_sender();
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        pause_sender();
        while (awaited_steps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            REG_ITEM_COUNT: begin
                cfg_count = data[CFG_CNT_W-1:0];
                deal_pending = 1'b1;
            end
            REG_PLAY_MODE: begin
                cfg_mode = data[MODE_W-1:0];
                deal_pending = 1'b1;
            end
            REG_RANDOM_SEED: begin
                rng_state = data;
            end
            default: ;
        endcase
    endtask

    task automatic test_empty_list();
        logic [CUR_W-1:0] nx;
        send_step(1'b0, 10'd0, nx);
        send_step(1'b1, 10'd1023, nx);
        send_step(1'b0, 10'd512, nx);
        write_register(REG_PLAY_MODE, {30'd0, MODE_RND});
        send_step(1'b0, 10'd5, nx);
    endtask

    task automatic test_step_modes();
        logic [CUR_W-1:0] nx;
        // junk above the register width must be dropped
        write_register(REG_ITEM_COUNT, 32'hABCD_F400);
        write_register(REG_PLAY_MODE, {30'h3FFF_FFFF, MODE_SEQ});
        send_step(1'b0, 10'd1023, nx);
        send_step(1'b0, 10'd0, nx);
        send_step(1'b1, 10'd0, nx);
        write_register(REG_PLAY_MODE, {30'h1555_5555, MODE_REV});
        send_step(1'b0, 10'd0, nx);
        send_step(1'b0, 10'd1023, nx);
        write_register(REG_PLAY_MODE, {30'd0, MODE_SPARE});
        send_step(1'b0, 10'd1023, nx);
        // count above the table size is clamped
        write_register(REG_ITEM_COUNT, 32'd2047);
        send_step(1'b0, 10'd1023, nx);
        send_step(1'b1, 10'd0, nx);
        // index beyond the list end
        write_register(REG_ITEM_COUNT, 32'd5);
        write_register(REG_PLAY_MODE, {30'd0, MODE_SEQ});
        send_step(1'b0, 10'd1023, nx);
        send_step(1'b1, 10'd1023, nx);
        write_register(REG_ITEM_COUNT, 32'd1);
        send_step(1'b0, 10'd0, nx);
        send_step(1'b1, 10'd0, nx);
    endtask

    task automatic test_shuffle_edges();
        logic [CUR_W-1:0] nx;
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        write_register(REG_RANDOM_SEED, 32'hFFFF_FFFF);
        write_register(REG_PLAY_MODE, {30'd0, MODE_RND});
        write_register(REG_ITEM_COUNT, 32'd1);
        send_step(1'b0, 10'd0, nx);
        send_step(1'b0, nx, nx);
        write_register(REG_ITEM_COUNT, 32'd2);
        nx = 10'd1;
        repeat (4) send_step(1'b0, nx, nx);
        // a zero generator state never moves
        write_register(REG_RANDOM_SEED, 32'd0);
        write_register(REG_ITEM_COUNT, 32'd8);
        repeat (3) send_step(1'b0, nx, nx);
        write_register(REG_RANDOM_SEED, 32'h8000_0001);
        write_register(REG_ITEM_COUNT, 32'd1024);
        send_step(1'b0, 10'd1023, nx);
        send_step(1'b0, nx, nx);
    endtask

    task automatic test_output_backpressure();
        logic [CUR_W-1:0] nx;
        write_register(REG_ITEM_COUNT, 32'd100);
        write_register(REG_PLAY_MODE, {30'd0, MODE_SEQ});
        steady_flow = 1'b1;
        hold_calls++;
        nx = 10'd90;
        repeat (30) send_step(1'b0, nx, nx);
        steady_flow = 1'b0;
    endtask

    task automatic test_random_playback(input int unsigned target);
        int unsigned pick;
        int unsigned phase_len;
        int unsigned k;
        logic [CFG_CNT_W-1:0] cnt;
        logic [MODE_W-1:0] md;
        logic [CUR_W-1:0] cur;
        logic [CUR_W-1:0] nx;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) cnt = '0;
            else if (pick < 75) cnt = CFG_CNT_W'($urandom_range(1, 40));
            else if (pick < 96) cnt = CFG_CNT_W'($urandom_range(41, 300));
            else cnt = CFG_CNT_W'($urandom_range(1000, 2047));
            pick = $urandom_range(0, 9);
            if (pick < 5) md = MODE_RND;
            else if (pick < 7) md = MODE_SEQ;
            else if (pick < 9) md = MODE_REV;
            else md = MODE_SPARE;
            if ($urandom_range(0, 3) == 0)
                write_register(REG_RANDOM_SEED,
                               ($urandom_range(0, 15) == 0) ? 32'd0 : $urandom());
            if ($urandom_range(0, 1) == 0) begin
                write_register(REG_ITEM_COUNT, {21'($urandom()), cnt});
                write_register(REG_PLAY_MODE, {30'($urandom()), md});
            end else begin
                write_register(REG_PLAY_MODE, {30'($urandom()), md});
                write_register(REG_ITEM_COUNT, {21'($urandom()), cnt});
            end
            steady_flow = ($urandom_range(0, 4) == 0);
            steady_sink = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(10, 80);
            cur = CUR_W'($urandom());
            for (k = 0; k < phase_len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) send_step(1'b0, cur, nx);
                else if (pick < 90) send_step(1'b1, cur, nx);
                else send_step(1'($urandom()), CUR_W'($urandom()), nx);
                cur = nx;
            end
        end
        steady_flow = 1'b0;
        steady_sink = 1'b0;
    endtask

    // result sink: stall pattern, plus one long hold on request
    always @(posedge aclk) begin
        sink_age <= sink_age + 1'b1;
        if (sink_age == 6'd63)
            sink_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
        else
            sink_pat <= {sink_pat[0], sink_pat[15:1]};
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_calls != hold_served) begin
            m_tready <= 1'b0;
            hold_served <= hold_calls;
            hold_left <= LONG_HOLD;
        end else begin
            m_tready <= steady_sink | sink_pat[0];
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (awaited_steps.size() == 0) begin
                report_mismatch("unexpected result, index", m_tdata, 16'h0);
            end else begin
                head_step = awaited_steps.pop_front();
                if (m_tdata !== {{(16-CUR_W){1'b0}}, head_step.next_index})
                    report_mismatch("next_index", m_tdata,
                                    {{(16-CUR_W){1'b0}}, head_step.next_index});
                if (m_tuser[0] !== head_step.list_empty)
                    report_mismatch("list_empty", {15'd0, m_tuser[0]},
                                    {15'd0, head_step.list_empty});
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", awaited_steps.size());
            $display("FAIL shuffle_playlist_sequencer_top");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_list();
        test_step_modes();
        test_shuffle_edges();
        test_output_backpressure();
        test_random_playback(ITEM_TARGET);
        pause_sender();
        while (awaited_steps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d requests and %0d results over %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("shuffled order dealt %0d times, first-entry swap taken %0d times",
                 shuffles_dealt, swaps_taken);
        if (mismatches == 0) begin
            $display("PASS shuffle_playlist_sequencer_top");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAIL shuffle_playlist_sequencer_top");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/shplseq_pkg.sv
hdl/shplseq_ram.sv
hdl/shplseq_mod_unit.sv
hdl/shuffle_playlist_sequencer_top.sv
verif/tb_shuffle_playlist_sequencer_top.sv
